>>> design/msdp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// msdp_pkg: shared types and constants of the masked seam finder
// Register map, operation codes, back-pointer and shift-side codes, the
// sequencer states and the configuration bundle.
// ============================================================================
package msdp_pkg;

    localparam int DEF_MAX_LINE_LEN = 512;
    localparam int DEF_MAX_LINES    = 512;
    localparam int DEF_COST_WIDTH   = 32;

    localparam int CFG_AW     = 4;
    localparam int CFG_DW     = 32;
    localparam int LEN_CFG_W  = 10;
    localparam int PEN_W      = 16;
    localparam int ENERGY_W   = 16;
    localparam int OUT_LINE_W = 9;
    localparam int OUT_POS_W  = 9;
    localparam int SIDE_W     = 2;
    localparam int BP_W       = 2;

    localparam logic [LEN_CFG_W-1:0] RST_LINE_LENGTH  = 10'd512;
    localparam logic [LEN_CFG_W-1:0] RST_LINE_COUNT   = 10'd512;
    localparam logic                 RST_TOWARD_START = 1'b1;
    localparam logic [PEN_W-1:0]     RST_SEAM_PENALTY = 16'h8000;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        REG_LINE_LENGTH,
        REG_LINE_COUNT,
        REG_TOWARD_START,
        REG_SEAM_PENALTY
    } t_reg;

    typedef enum logic [BP_W-1:0] {
        BP_CENTRE = 2'd0,
        BP_MINUS  = 2'd1,
        BP_PLUS   = 2'd2
    } t_bp;

    typedef enum logic [SIDE_W-1:0] {
        SIDE_START = 2'd0,
        SIDE_END   = 2'd1,
        SIDE_NONE  = 2'd2
    } t_side;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SELECT,
        ST_UPDATE,
        ST_COMMIT,
        ST_TRACE
    } t_state;

    typedef struct packed {
        logic [LEN_CFG_W-1:0] line_length;
        logic [LEN_CFG_W-1:0] line_count;
        logic                 toward_start;
        logic [PEN_W-1:0]     seam_penalty;
    } t_cfg;

endpackage

>>> design/msdp_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// msdp_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module msdp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/msdp_regs.sv
`timescale 1ns / 1ps
// ============================================================================
// msdp_regs: configuration register file
// APB-style slave with zero wait states; holds line length, line count,
// shift preference and seam penalty.
// ============================================================================
module msdp_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [msdp_pkg::CFG_AW-1:0]  paddr,
    input  logic [msdp_pkg::CFG_DW-1:0]  pwdata,
    output logic [msdp_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready,
    output msdp_pkg::t_cfg               o_cfg
);
    import msdp_pkg::*;

    t_cfg r_cfg;
    t_reg reg_sel;
    logic wr_en;

    assign pready  = 1'b1;
    assign reg_sel = t_reg'(paddr[CFG_AW-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_length  <= RST_LINE_LENGTH;
            r_cfg.line_count   <= RST_LINE_COUNT;
            r_cfg.toward_start <= RST_TOWARD_START;
            r_cfg.seam_penalty <= RST_SEAM_PENALTY;
        end else if (wr_en) begin
            case (reg_sel)
                REG_LINE_LENGTH:  r_cfg.line_length  <= pwdata[LEN_CFG_W-1:0];
                REG_LINE_COUNT:   r_cfg.line_count   <= pwdata[LEN_CFG_W-1:0];
                REG_TOWARD_START: r_cfg.toward_start <= pwdata[0];
                REG_SEAM_PENALTY: r_cfg.seam_penalty <= pwdata[PEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_LINE_LENGTH:  prdata = CFG_DW'(r_cfg.line_length);
            REG_LINE_COUNT:   prdata = CFG_DW'(r_cfg.line_count);
            REG_TOWARD_START: prdata = CFG_DW'(r_cfg.toward_start);
            REG_SEAM_PENALTY: prdata = CFG_DW'(r_cfg.seam_penalty);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/masked_seam_dp_with_backtrack.sv
`timescale 1ns / 1ps
// ============================================================================
// masked_seam_dp_with_backtrack: minimum-energy seam finder with backtrack
// Builds seam costs line by line in a ping-pong cost memory, stores
// back-pointers in a second memory, then pops the seam from last line to first.
// ============================================================================
//
//  Port group   Direction  Handshake             Payload
//  ----------   ---------  --------------------  ------------------------------
//  config       in/out     psel/penable/pready   paddr, pwdata, prdata
//  input        in         i_in_valid/o_in_stall operation, energy, border, seamed
//  result       out        o_out_valid/i_out_stall line, position, side, done
//
//  A load in line 0 runs UPDATE, COMMIT; in later lines SELECT, UPDATE, COMMIT,
//  with FETCH first at a line's first pixel; a pop runs TRACE. The sequencer
//  serves one transaction at a time around the single read port of each memory.
//  Reset clears counters and the best-cost tracker; the memories are not
//  cleared and need no clearing pass.
//  A result waits in the output register; input stalls while the sequencer is
//  busy or while a held result is stalled.
//
module masked_seam_dp_with_backtrack #(
    parameter int MAX_LINE_LEN = msdp_pkg::DEF_MAX_LINE_LEN,
    parameter int MAX_LINES    = msdp_pkg::DEF_MAX_LINES,
    parameter int COST_WIDTH   = msdp_pkg::DEF_COST_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [msdp_pkg::CFG_AW-1:0]     paddr,
    input  logic [msdp_pkg::CFG_DW-1:0]     pwdata,
    output logic [msdp_pkg::CFG_DW-1:0]     prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_operation,
    input  logic [msdp_pkg::ENERGY_W-1:0]   i_energy_value,
    input  logic                            i_is_border,
    input  logic                            i_already_seamed,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [msdp_pkg::OUT_LINE_W-1:0] o_line_index,
    output logic [msdp_pkg::OUT_POS_W-1:0]  o_seam_position,
    output logic [msdp_pkg::SIDE_W-1:0]     o_shift_side,
    output logic                            o_seam_done
);
    import msdp_pkg::*;

    localparam int PW     = $clog2(MAX_LINE_LEN);
    localparam int PW1    = $clog2(MAX_LINE_LEN + 1);
    localparam int LW     = $clog2(MAX_LINES);
    localparam int LW1    = $clog2(MAX_LINES + 1);
    localparam int CDEPTH = 2 * MAX_LINE_LEN;
    localparam int CAW    = $clog2(CDEPTH);
    localparam int BDEPTH = MAX_LINES * MAX_LINE_LEN;
    localparam int BAW    = $clog2(BDEPTH);
    localparam int SUMW   = COST_WIDTH + 2;
    localparam logic [COST_WIDTH-1:0] COST_MAX = '1;

    // configuration
    t_cfg            cfg;
    logic [PW1-1:0]  eff_len;
    logic [LW1-1:0]  eff_cnt;

    // control state
    t_state          r_state, n_state;
    logic [LW1-1:0]  r_load_line;
    logic [PW1-1:0]  r_load_pos;
    logic [PW-1:0]   r_best_pos;
    logic [COST_WIDTH-1:0] r_best_cost;
    logic [LW1-1:0]  r_trace;
    logic            r_bank;
    logic            r_pop_ok;
    logic            r_out_valid;

    // per-transaction payload
    logic [LW-1:0]   r_line;
    logic [PW-1:0]   r_pos;
    logic [ENERGY_W-1:0] r_energy;
    logic            r_border;
    logic            r_seamed;
    logic [COST_WIDTH-1:0] r_left, r_mid, r_min, r_cost;
    t_bp             r_bp;
    logic [PW-1:0]   r_pop_pos;
    logic            r_pop_last;
    logic [OUT_LINE_W-1:0] r_out_line;
    logic [OUT_POS_W-1:0]  r_out_pos;
    t_side           r_out_side;
    logic            r_out_done;

    // memory ports
    logic            cost_we;
    logic [CAW-1:0]  cost_waddr, cost_raddr;
    logic [COST_WIDTH-1:0] cost_rdata;
    logic            bp_we;
    logic [BAW-1:0]  bp_waddr, bp_raddr;
    logic [BP_W-1:0] bp_rdata;

    // accept decode
    logic            in_accept, ld_go, pop_go;
    logic            restart0, wrap, restart1, ld_restart;
    logic [LW1-1:0]  l_a, l_b, ld_line;
    logic [PW1-1:0]  p_a, ld_pos, ld_pos_inc;
    logic            ld_prev_bank;
    logic [PW-1:0]   ld_rpos, fetch_rpos;

    // pop decode
    logic            pop_ok;
    logic [LW1-1:0]  tline;
    logic [PW-1:0]   ppos;
    t_side           pop_side;
    logic [BAW-1:0]  pop_addr;

    // datapath
    logic            has_right;
    logic [COST_WIDTH-1:0] sel_min;
    t_bp             sel_bp;
    logic [SUMW-1:0] upd_sum;
    logic [COST_WIDTH-1:0] upd_cost;
    logic [PW1-1:0]  next_pos;
    logic            line_end, last_line, best_upd;
    t_bp             tr_code;
    logic [PW-1:0]   tr_pos;

    msdp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    msdp_ram #(.WIDTH(COST_WIDTH), .DEPTH(CDEPTH)) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (cost_we),
        .i_waddr (cost_waddr),
        .i_wdata (r_cost),
        .i_raddr (cost_raddr),
        .o_rdata (cost_rdata)
    );

    msdp_ram #(.WIDTH(BP_W), .DEPTH(BDEPTH)) u_bp_ram (
        .i_clk   (i_clk),
        .i_we    (bp_we),
        .i_waddr (bp_waddr),
        .i_wdata (r_bp),
        .i_raddr (bp_raddr),
        .o_rdata (bp_rdata)
    );

    // effective length and count
    always_comb begin
        if (cfg.line_length == '0) begin
            eff_len = PW1'(1);
        end else if (32'(cfg.line_length) > 32'(MAX_LINE_LEN)) begin
            eff_len = PW1'(MAX_LINE_LEN);
        end else begin
            eff_len = PW1'(cfg.line_length);
        end
        if (cfg.line_count == '0) begin
            eff_cnt = LW1'(1);
        end else if (32'(cfg.line_count) > 32'(MAX_LINES)) begin
            eff_cnt = LW1'(MAX_LINES);
        end else begin
            eff_cnt = LW1'(cfg.line_count);
        end
    end

    assign in_accept = i_in_valid && !o_in_stall;
    assign ld_go     = in_accept && (i_operation == OP_LOAD);
    assign pop_go    = in_accept && (i_operation == OP_POP);

    // load position after frame restart and line wrap
    always_comb begin
        restart0   = r_load_line >= eff_cnt;
        l_a        = restart0 ? '0 : r_load_line;
        p_a        = restart0 ? '0 : r_load_pos;
        wrap       = p_a >= eff_len;
        l_b        = wrap ? l_a + LW1'(1) : l_a;
        restart1   = wrap && (l_b >= eff_cnt);
        ld_line    = restart1 ? '0 : l_b;
        ld_pos     = wrap ? '0 : p_a;
        ld_restart = restart0 || restart1;
        ld_pos_inc = ld_pos + PW1'(1);
        ld_prev_bank = r_bank ^ !wrap;
        if (ld_pos == '0) begin
            ld_rpos = '0;
        end else if (ld_pos_inc < eff_len) begin
            ld_rpos = PW'(ld_pos_inc);
        end else begin
            ld_rpos = PW'(ld_pos);
        end
        fetch_rpos = (PW1'(1) < eff_len) ? PW'(1) : '0;
    end

    // pop decode
    always_comb begin
        pop_ok = (r_load_line == eff_cnt) && (r_trace < eff_cnt);
        tline  = eff_cnt - LW1'(1) - r_trace;
        if (PW1'(r_best_pos) >= eff_len) begin
            ppos = PW'(eff_len - PW1'(1));
        end else begin
            ppos = r_best_pos;
        end
        if (cfg.toward_start && (ppos != '0)) begin
            pop_side = SIDE_START;
        end else if ((PW1'(ppos) + PW1'(1)) < eff_len) begin
            pop_side = SIDE_END;
        end else begin
            pop_side = SIDE_NONE;
        end
        pop_addr = BAW'(LW'(tline)) * BAW'(MAX_LINE_LEN) + BAW'(ppos);
    end

    // neighbour selection: centre first, then minus, then plus, on strict less
    always_comb begin
        has_right = (PW1'(r_pos) + PW1'(1)) < eff_len;
        sel_min   = r_mid;
        sel_bp    = BP_CENTRE;
        if ((r_pos != '0) && (r_left < sel_min)) begin
            sel_min = r_left;
            sel_bp  = BP_MINUS;
        end
        if (has_right && (cost_rdata < sel_min)) begin
            sel_min = cost_rdata;
            sel_bp  = BP_PLUS;
        end
    end

    // cost update with saturation
    always_comb begin
        upd_sum = SUMW'(r_energy) + SUMW'(r_min)
                + (r_seamed ? SUMW'(cfg.seam_penalty) : SUMW'(0));
        if (r_line == '0) begin
            upd_cost = COST_WIDTH'(r_energy);
        end else if (r_border) begin
            upd_cost = COST_MAX;
        end else if (upd_sum > SUMW'(COST_MAX)) begin
            upd_cost = COST_MAX;
        end else begin
            upd_cost = upd_sum[COST_WIDTH-1:0];
        end
    end

    // commit and backtrack step
    always_comb begin
        next_pos  = PW1'(r_pos) + PW1'(1);
        line_end  = next_pos >= eff_len;
        last_line = (LW1'(r_line) + LW1'(1)) == eff_cnt;
        best_upd  = last_line && ((r_pos == '0) || (r_cost < r_best_cost));
        tr_code   = t_bp'(bp_rdata);
        tr_pos    = r_pop_pos;
        if (!r_pop_last) begin
            if ((tr_code == BP_MINUS) && (r_pop_pos != '0)) begin
                tr_pos = r_pop_pos - PW'(1);
            end else if ((tr_code == BP_PLUS)
                         && ((PW1'(r_pop_pos) + PW1'(1)) < eff_len)) begin
                tr_pos = r_pop_pos + PW'(1);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (ld_go) begin
                    if (ld_line == '0) begin
                        n_state = ST_UPDATE;
                    end else if (ld_pos == '0) begin
                        n_state = ST_FETCH;
                    end else begin
                        n_state = ST_SELECT;
                    end
                end else if (pop_go) begin
                    n_state = ST_TRACE;
                end
            end
            ST_FETCH:  n_state = ST_SELECT;
            ST_SELECT: n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_COMMIT;
            ST_COMMIT: n_state = ST_IDLE;
            ST_TRACE:  n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall = (r_out_valid && i_out_stall);
        cost_raddr = '0;
        cost_we    = 1'b0;
        bp_we      = 1'b0;
        bp_raddr   = '0;
        cost_waddr = r_bank ? CAW'(MAX_LINE_LEN) + CAW'(r_pos) : CAW'(r_pos);
        bp_waddr   = BAW'(r_line) * BAW'(MAX_LINE_LEN) + BAW'(r_pos);
        case (r_state)
            ST_IDLE: begin
                cost_raddr = ld_prev_bank ? CAW'(MAX_LINE_LEN) + CAW'(ld_rpos)
                                          : CAW'(ld_rpos);
                bp_raddr   = pop_addr;
            end
            ST_FETCH: begin
                o_in_stall = 1'b1;
                cost_raddr = !r_bank ? CAW'(MAX_LINE_LEN) + CAW'(fetch_rpos)
                                     : CAW'(fetch_rpos);
            end
            ST_SELECT: o_in_stall = 1'b1;
            ST_UPDATE: o_in_stall = 1'b1;
            ST_COMMIT: begin
                o_in_stall = 1'b1;
                cost_we    = 1'b1;
                bp_we      = 1'b1;
            end
            ST_TRACE:  o_in_stall = 1'b1;
            default:   o_in_stall = 1'b1;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_load_line <= '0;
            r_load_pos  <= '0;
            r_best_pos  <= '0;
            r_best_cost <= COST_MAX;
            r_trace     <= '0;
            r_bank      <= 1'b0;
            r_pop_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ld_go) begin
                r_bank <= r_bank ^ wrap;
                if (ld_restart) begin
                    r_best_cost <= COST_MAX;
                    r_best_pos  <= '0;
                    r_trace     <= '0;
                end
            end
            if (pop_go) begin
                r_pop_ok <= pop_ok;
            end
            if (r_state == ST_COMMIT) begin
                if (best_upd) begin
                    r_best_cost <= r_cost;
                    r_best_pos  <= r_pos;
                end
                if (line_end) begin
                    r_load_pos  <= '0;
                    r_load_line <= LW1'(r_line) + LW1'(1);
                    r_bank      <= ~r_bank;
                end else begin
                    r_load_pos  <= next_pos;
                    r_load_line <= LW1'(r_line);
                end
            end
            if ((r_state == ST_TRACE) && r_pop_ok) begin
                r_best_pos <= tr_pos;
                r_trace    <= r_trace + LW1'(1);
            end
            if (pop_go && pop_ok) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (ld_go) begin
            r_line   <= LW'(ld_line);
            r_pos    <= PW'(ld_pos);
            r_energy <= i_energy_value;
            r_border <= i_is_border;
            r_seamed <= i_already_seamed;
            r_bp     <= BP_CENTRE;
        end
        if (r_state == ST_FETCH) begin
            r_mid <= cost_rdata;
        end
        if (r_state == ST_SELECT) begin
            r_min  <= sel_min;
            r_bp   <= sel_bp;
            r_left <= r_mid;
            r_mid  <= cost_rdata;
        end
        if (r_state == ST_UPDATE) begin
            r_cost <= upd_cost;
        end
        if (pop_go) begin
            r_pop_pos  <= ppos;
            r_pop_last <= (tline == '0);
        end
        if (pop_go && pop_ok) begin
            r_out_line <= OUT_LINE_W'(LW'(tline));
            r_out_pos  <= OUT_POS_W'(ppos);
            r_out_side <= pop_side;
            r_out_done <= (tline == '0);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_line_index    = r_out_line;
    assign o_seam_position = r_out_pos;
    assign o_shift_side    = r_out_side;
    assign o_seam_done     = r_out_done;

endmodule

>>> design/msdp_chk.sv
`timescale 1ns / 1ps
// ============================================================================
// msdp_chk: port-level checker for the masked seam finder
// Watches the input and result channels of the top level over time.
// ============================================================================
module msdp_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [msdp_pkg::OUT_LINE_W-1:0] o_line_index,
    input logic [msdp_pkg::OUT_POS_W-1:0]  o_seam_position,
    input logic [msdp_pkg::SIDE_W-1:0]     o_shift_side,
    input logic                            o_seam_done
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_line_index)
            && $stable(o_seam_position) && $stable(o_shift_side)
            && $stable(o_seam_done))
        else $error("held result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted back to back");

    a_stall_on_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input open while result is stalled");

    a_done_on_line0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_seam_done |-> o_line_index == '0)
        else $error("seam end flagged on a line other than the first");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind masked_seam_dp_with_backtrack msdp_chk u_msdp_chk (.*);

>>> test/masked_seam_dp_with_backtrack_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// masked_seam_dp_with_backtrack_tb: seam finder cost, back-pointer and pop test
// Streams pixel frames and pop requests through the valid/stall input, mirrors
// the line-by-line cost build and the backtrack in a local seam ledger, and
// compares every popped seam element field by field. Covers the register
// extremes, border and seamed pixels, a length cut inside a frame, early and
// surplus pops, and a long output hold-off that backs up the input.
// ============================================================================
module masked_seam_dp_with_backtrack_tb;
    import msdp_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int MAX_COLS       = DEF_MAX_LINE_LEN;
    localparam int MAX_ROWS       = DEF_MAX_LINES;
    localparam int CW             = DEF_COST_WIDTH;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 300;

    typedef struct packed {
        logic [OUT_LINE_W-1:0] line_no;
        logic [OUT_POS_W-1:0]  position;
        t_side                 side;
        logic                  last;
    } t_seam_elem;

    class t_seam_ledger;
        logic [LEN_CFG_W-1:0] len_reg;
        logic [LEN_CFG_W-1:0] cnt_reg;
        logic                 toward_reg;
        logic [PEN_W-1:0]     pen_reg;
        bit [CW-1:0]          prev_cost[MAX_COLS];
        bit [CW-1:0]          cur_cost[MAX_COLS];
        t_bp                  bp_mem[MAX_ROWS*MAX_COLS];
        int                   row;
        int                   col;
        int                   best_pos;
        int                   traced;
        bit [CW-1:0]          best_cost;
        t_seam_elem           owed[$];
        int                   errors;

        function new();
            len_reg    = RST_LINE_LENGTH;
            cnt_reg    = RST_LINE_COUNT;
            toward_reg = RST_TOWARD_START;
            pen_reg    = RST_SEAM_PENALTY;
            row        = 0;
            col        = 0;
            best_pos   = 0;
            traced     = 0;
            best_cost  = '1;
            errors     = 0;
        endfunction

        function int eff_len();
            if (len_reg == 0)
                return 1;
            return (len_reg > MAX_COLS) ? MAX_COLS : int'(len_reg);
        endfunction

        function bit [CW-1:0] sat_add(bit [CW-1:0] a, bit [CW-1:0] b);
            bit [CW:0] s;
            s = a + b;
            return s[CW] ? '1 : s[CW-1:0];
        endfunction

        function void close_line();
            prev_cost = cur_cost;
            col = 0;
            row++;
        endfunction

        function void set_reg(t_reg idx, logic [CFG_DW-1:0] value);
            case (idx)
                REG_LINE_LENGTH:  len_reg    = value[LEN_CFG_W-1:0];
                REG_LINE_COUNT:   cnt_reg    = value[LEN_CFG_W-1:0];
                REG_TOWARD_START: toward_reg = value[0];
                REG_SEAM_PENALTY: pen_reg    = value[PEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_input(logic op, logic [ENERGY_W-1:0] energy, logic border,
                                 logic seamed);
            int          len;
            int          cnt;
            int          pos;
            int          line;
            bit [CW-1:0] cost;
            bit [CW-1:0] least;
            t_bp         ptr;
            t_seam_elem  e;
            len = eff_len();
            cnt = (cnt_reg == 0) ? 1 : ((cnt_reg > MAX_ROWS) ? MAX_ROWS : int'(cnt_reg));
            if (op == OP_LOAD) begin
                if (row < cnt && col >= len)
                    close_line();
                if (row >= cnt) begin
                    row       = 0;
                    col       = 0;
                    traced    = 0;
                    best_pos  = 0;
                    best_cost = '1;
                end
                ptr  = BP_CENTRE;
                pos  = col;
                cost = CW'(energy);
                if (row > 0) begin
                    least = prev_cost[pos];
                    if (pos > 0 && prev_cost[pos-1] < least) begin
                        least = prev_cost[pos-1];
                        ptr   = BP_MINUS;
                    end
                    if (pos + 1 < len && prev_cost[pos+1] < least) begin
                        least = prev_cost[pos+1];
                        ptr   = BP_PLUS;
                    end
                    cost = sat_add(cost, least);
                    if (border)
                        cost = '1;
                    else if (seamed)
                        cost = sat_add(cost, CW'(pen_reg));
                end
                cur_cost[pos] = cost;
                bp_mem[row*MAX_COLS + pos] = ptr;
                if (row + 1 == cnt && (pos == 0 || cost < best_cost)) begin
                    best_cost = cost;
                    best_pos  = pos;
                end
                col = pos + 1;
                if (col >= len)
                    close_line();
            end else if (row == cnt && traced < cnt) begin
                line = cnt - 1 - traced;
                pos  = (best_pos >= len) ? len - 1 : best_pos;
                if (toward_reg && pos > 0)
                    e.side = SIDE_START;
                else if (pos + 1 < len)
                    e.side = SIDE_END;
                else
                    e.side = SIDE_NONE;
                e.line_no  = OUT_LINE_W'(line);
                e.position = OUT_POS_W'(pos);
                e.last     = (line == 0);
                if (line > 0) begin
                    ptr = bp_mem[line*MAX_COLS + pos];
                    if (ptr == BP_MINUS && pos > 0)
                        pos--;
                    else if (ptr == BP_PLUS && pos + 1 < len)
                        pos++;
                end
                best_pos = pos;
                traced++;
                owed = {owed, e};
            end
        endfunction

        task report(string field, int got, int want);
            $display("seam mismatch: %s got %0d expected %0d", field, got, want);
            errors++;
        endtask

        task check_result(logic [OUT_LINE_W-1:0] line_no, logic [OUT_POS_W-1:0] position,
                          logic [SIDE_W-1:0] side, logic last);
            t_seam_elem e;
            if (owed.size() == 0) begin
                report("unexpected element, line_index", int'(line_no), 0);
            end else begin
                e = owed.pop_front();
                if (line_no !== e.line_no)
                    report("line_index", int'(line_no), int'(e.line_no));
                if (position !== e.position)
                    report("seam_position", int'(position), int'(e.position));
                if (side !== e.side)
                    report("shift_side", int'(side), int'(e.side));
                if (last !== e.last)
                    report("seam_done", int'(last), int'(e.last));
            end
        endtask
    endclass

    logic                   i_clk            = 1'b0;
    logic                   i_rst_n          = 1'b0;
    logic                   psel             = 1'b0;
    logic                   penable          = 1'b0;
    logic                   pwrite           = 1'b0;
    logic [CFG_AW-1:0]      paddr            = '0;
    logic [CFG_DW-1:0]      pwdata           = '0;
    logic [CFG_DW-1:0]      prdata;
    logic                   pready;
    logic                   i_in_valid       = 1'b0;
    logic                   o_in_stall;
    logic                   i_operation      = OP_LOAD;
    logic [ENERGY_W-1:0]    i_energy_value   = '0;
    logic                   i_is_border      = 1'b0;
    logic                   i_already_seamed = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall      = 1'b0;
    logic [OUT_LINE_W-1:0]  o_line_index;
    logic [OUT_POS_W-1:0]   o_seam_position;
    logic [SIDE_W-1:0]      o_shift_side;
    logic                   o_seam_done;

    t_seam_ledger ledger;
    int         burst_left   = 0;
    int         hold_ticket  = 0;
    int         hold_seen    = 0;
    int         hold_left    = 0;
    int         pattern_left = 0;
    int         stall_style  = 0;
    int         random_items = 0;

    masked_seam_dp_with_backtrack DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_energy_value   (i_energy_value),
        .i_is_border      (i_is_border),
        .i_already_seamed (i_already_seamed),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_line_index     (o_line_index),
        .o_seam_position  (o_seam_position),
        .o_shift_side     (o_shift_side),
        .o_seam_done      (o_seam_done)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // receiver: long hold-off on request, otherwise a changing stall pattern
    always @(posedge i_clk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen   <= hold_ticket;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            if (pattern_left == 0) begin
                pattern_left <= $urandom_range(8, 64);
                stall_style  <= $urandom_range(0, 3);
            end else begin
                pattern_left <= pattern_left - 1;
            end
            case (stall_style)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= 1'($urandom_range(0, 1));
                default: i_out_stall <= (pattern_left[1:0] != 2'd0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            ledger.check_result(o_line_index, o_seam_position, o_shift_side, o_seam_done);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("masked_seam_dp_with_backtrack verification failed");
        $finish;
    end

    function automatic logic [ENERGY_W-1:0] rand_energy();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return ENERGY_W'($urandom_range(0, 64));
            default: return ENERGY_W'($urandom);
        endcase
    endfunction

    task automatic send_item(logic op, logic [ENERGY_W-1:0] energy, logic border,
                             logic seamed);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_in_valid       <= 1'b1;
        i_operation      <= op;
        i_energy_value   <= energy;
        i_is_border      <= border;
        i_already_seamed <= seamed;
        do @(posedge i_clk); while (o_in_stall);
        ledger.note_input(op, energy, border, seamed);
    endtask

    // hold input until every owed element is out, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (ledger.owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [CFG_DW-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        ledger.set_reg(idx, value);
    endtask

    task automatic configure(logic [LEN_CFG_W-1:0] len, logic [LEN_CFG_W-1:0] cnt,
                             logic toward, logic [PEN_W-1:0] pen);
        drain();
        write_reg(REG_LINE_LENGTH, CFG_DW'(len));
        write_reg(REG_LINE_COUNT, CFG_DW'(cnt));
        write_reg(REG_TOWARD_START, CFG_DW'(toward));
        write_reg(REG_SEAM_PENALTY, CFG_DW'(pen));
    endtask

    task automatic run_frame(int lines, int width, int pops, int border_odds, bit noisy,
                             bit hold);
        for (int r = 0; r < lines; r++) begin
            for (int c = 0; c < width; c++) begin
                if (noisy && $urandom_range(0, 15) == 0)
                    send_item(OP_POP, rand_energy(), 1'($urandom), 1'($urandom));
                send_item(OP_LOAD, rand_energy(), $urandom_range(0, 15) < border_odds,
                          $urandom_range(0, 3) == 0);
            end
        end
        if (hold)
            hold_ticket <= hold_ticket + 1;
        repeat (pops) send_item(OP_POP, rand_energy(), 1'($urandom), 1'($urandom));
    endtask

    initial begin
        int lines;
        int width;
        int pops;
        ledger = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one pixel per line; back up the output on pops
        configure(10'd0, 10'd24, 1'b1, 16'hFFFF);
        run_frame(24, 1, 26, 2, 1'b0, 1'b1);

        // first line ignores flags, ties, early pop, all-inf last line, surplus pops
        configure(10'd4, 10'd3, 1'b1, RST_SEAM_PENALTY);
        send_item(OP_LOAD, 16'hFFFF, 1'b1, 1'b1);
        send_item(OP_LOAD, 16'h0000, 1'b1, 1'b0);
        send_item(OP_LOAD, 16'h0000, 1'b0, 1'b1);
        send_item(OP_LOAD, 16'hFFFF, 1'b0, 1'b0);
        send_item(OP_POP, 16'h0000, 1'b0, 1'b0);
        send_item(OP_LOAD, 16'h0001, 1'b0, 1'b1);
        send_item(OP_LOAD, 16'h8000, 1'b1, 1'b0);
        send_item(OP_LOAD, 16'h0002, 1'b0, 1'b0);
        send_item(OP_LOAD, 16'h0000, 1'b0, 1'b1);
        send_item(OP_LOAD, 16'hFFFF, 1'b1, 1'b0);
        send_item(OP_LOAD, 16'h0000, 1'b1, 1'b1);
        send_item(OP_LOAD, 16'h1234, 1'b1, 1'b0);
        send_item(OP_LOAD, 16'h0000, 1'b1, 1'b0);
        repeat (5) send_item(OP_POP, 16'hFFFF, 1'b1, 1'b1);

        // cut the line length in the middle of a line
        configure(10'd4, 10'd3, 1'b0, 16'hFFFF);
        send_item(OP_LOAD, 16'h0005, 1'b0, 1'b0);
        send_item(OP_LOAD, 16'h0003, 1'b0, 1'b0);
        send_item(OP_LOAD, 16'h0003, 1'b0, 1'b0);
        send_item(OP_LOAD, 16'h0007, 1'b0, 1'b0);
        send_item(OP_LOAD, 16'h0000, 1'b0, 1'b1);
        send_item(OP_LOAD, 16'hFFFF, 1'b0, 1'b0);
        configure(10'd2, 10'd3, 1'b0, 16'hFFFF);
        send_item(OP_LOAD, 16'h0001, 1'b0, 1'b0);
        send_item(OP_LOAD, 16'h0000, 1'b0, 1'b1);
        repeat (3) send_item(OP_POP, 16'h0000, 1'b0, 1'b0);

        // long line, zero line count
        configure(10'd40, 10'd0, 1'b0, 16'h0000);
        run_frame(1, 40, 2, 2, 1'b0, 1'b0);

        while (random_items < RANDOM_ITEMS) begin
            width = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, 10);
            lines = $urandom_range(1, 8);
            pops  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, lines - 1)
                                                : lines + $urandom_range(0, 2);
            if ($urandom_range(0, 2) != 0) begin
                // a still open frame must not grow its lines
                if (ledger.row > 0 && ledger.row < lines && width > ledger.eff_len())
                    width = ledger.eff_len();
                configure(LEN_CFG_W'(width), LEN_CFG_W'(lines), 1'($urandom_range(0, 1)),
                          ($urandom_range(0, 3) == 0) ? PEN_W'($urandom_range(0, 1) * 16'hFFFF)
                                                      : PEN_W'($urandom));
            end
            width = ledger.eff_len();
            run_frame(lines, width, pops,
                      ($urandom_range(0, 9) == 0) ? 16 : $urandom_range(0, 4), 1'b1, 1'b0);
            random_items += lines * width + pops;
        end

        drain();
        if (ledger.errors == 0)
            $display("masked_seam_dp_with_backtrack verification clean");
        else
            $display("masked_seam_dp_with_backtrack verification failed");
        $finish;
    end

endmodule

>>> masked_seam_dp_with_backtrack.f
design/msdp_pkg.sv
design/msdp_ram.sv
design/msdp_regs.sv
design/masked_seam_dp_with_backtrack.sv
design/msdp_chk.sv
test/masked_seam_dp_with_backtrack_tb.sv
